/* hw/rtl/fsne_pkg.sv */
// Shared types and constants for the fixed-sum necklace enumerator.
// No dependencies; every other file of the block but fsne_ram uses it.
package fsne_pkg;

  localparam int MAX_LEN_DEF    = 16;
  localparam int ELEM_WIDTH_DEF = 8;

  // configuration register widths and reset values
  localparam int LEN_CFG_W   = 5;
  localparam int SUM_CFG_W   = 8;
  localparam int DEPTH_CFG_W = 5;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int INDEX_W     = 4;

  localparam int RST_LEN   = 4;
  localparam int RST_SUM   = 4;
  localparam int RST_DEPTH = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMIT_DEPTH = 2'd2;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef enum logic [1:0] {
    STG_DESCEND,
    STG_LOOP,
    STG_BACKTRACK
  } stage_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DESC,
    ST_DESC_RD,
    ST_LOOP,
    ST_LOOP_RD,
    ST_BT,
    ST_BT_RD,
    ST_MOD,
    ST_EMIT_LD,
    ST_EMIT_SHOW
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_SET_BT,
    CMD_RD_SRC,
    CMD_DESC_ADV,
    CMD_DESC_LOOP,
    CMD_RD_T,
    CMD_LOOP_ADV,
    CMD_BT_DEC,
    CMD_BT_LOWER,
    CMD_EXHAUST,
    CMD_MOD_START,
    CMD_MOD_STEP,
    CMD_FOUND,
    CMD_LOAD_OUT,
    CMD_OUT_NEXT
  } cmd_t;

  typedef struct packed {
    logic   past_depth;   // position beyond emit depth
    logic   full_len;     // emit depth equals length
    logic   sum_ok;       // running sum hit target, period nonzero
    logic   tail_ok;      // prefix can still be completed
    logic   t_ge2;
    logic   bound_fail;   // first-element bound prunes
    logic   fit;          // copied element keeps sum in range
    logic   v_gt_rem;
    logic   v_zero;
    logic   pos_low;      // position 0 or 1
    logic   mod_reached;
    logic   mod_hit;
    logic   last_shown;
    logic   exhausted;
    stage_t stage;
  } dp_stat_t;

endpackage

/* hw/rtl/fsne_if.sv */
// Valid/ready channel interfaces: request, result element and config write.
// Depends on fsne_pkg.
interface fsne_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface fsne_out_if #(
  parameter int ELEM_W = fsne_pkg::ELEM_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [ELEM_W-1:0]            element_value;
  logic [fsne_pkg::INDEX_W-1:0] element_index;
  logic                         last_element;
  logic                         done_res;
  modport source (output valid, output element_value, output element_index,
                  output last_element, output done_res, input ready);
  modport sink   (input valid, input element_value, input element_index,
                  input last_element, input done_res, output ready);
endinterface

interface fsne_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fsne_pkg::CFG_IDX_W-1:0]  index;
  logic [fsne_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/fsne_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fsne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/fsne_ctrl.sv */
// Search sequencer: walks descend/loop/backtrack steps and the output stream.
// Depends on fsne_pkg; drives commands into fsne_dp.
module fsne_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_restart,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  fsne_pkg::dp_stat_t stat,
  output fsne_pkg::cmd_t     cmd
);
  import fsne_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_restart) begin
          if (stat.exhausted) begin
            state_nxt = ST_EMIT_SHOW;
          end else begin
            unique case (stat.stage)
              STG_DESCEND:   state_nxt = ST_DESC;
              STG_LOOP:      state_nxt = ST_LOOP;
              STG_BACKTRACK: state_nxt = ST_BT;
              default:       state_nxt = ST_IDLE;
            endcase
          end
        end
      end
      ST_DESC: begin
        if (stat.past_depth) begin
          if (stat.full_len) begin
            state_nxt = stat.sum_ok ? ST_MOD : ST_BT;
          end else begin
            state_nxt = stat.tail_ok ? ST_EMIT_LD : ST_BT;
          end
        end else if (stat.t_ge2 && stat.bound_fail) begin
          state_nxt = ST_BT;
        end else begin
          state_nxt = ST_DESC_RD;
        end
      end
      ST_DESC_RD:  state_nxt = stat.fit ? ST_DESC : ST_LOOP;
      ST_LOOP:     state_nxt = ST_LOOP_RD;
      ST_LOOP_RD:  state_nxt = stat.v_gt_rem ? ST_BT : ST_DESC;
      ST_BT:       state_nxt = stat.pos_low ? ST_EMIT_SHOW : ST_BT_RD;
      ST_BT_RD:    state_nxt = stat.v_zero ? ST_BT : ST_LOOP;
      ST_MOD: begin
        if (stat.mod_reached) begin
          state_nxt = stat.mod_hit ? ST_EMIT_LD : ST_BT;
        end
      end
      ST_EMIT_LD:  state_nxt = ST_EMIT_SHOW;
      ST_EMIT_SHOW: begin
        if (out_ready) begin
          state_nxt = stat.last_shown ? ST_IDLE : ST_EMIT_LD;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = CMD_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_restart) begin
            cmd = CMD_INIT;
          end else if (stat.exhausted) begin
            cmd = CMD_EXHAUST;
          end
        end
      end
      ST_DESC: begin
        if (stat.past_depth) begin
          if (stat.full_len) begin
            cmd = stat.sum_ok ? CMD_MOD_START : CMD_SET_BT;
          end else begin
            cmd = stat.tail_ok ? CMD_FOUND : CMD_SET_BT;
          end
        end else if (stat.t_ge2 && stat.bound_fail) begin
          cmd = CMD_SET_BT;
        end else begin
          cmd = CMD_RD_SRC;
        end
      end
      ST_DESC_RD:  cmd = stat.fit ? CMD_DESC_ADV : CMD_DESC_LOOP;
      ST_LOOP:     cmd = CMD_RD_T;
      ST_LOOP_RD:  cmd = stat.v_gt_rem ? CMD_SET_BT : CMD_LOOP_ADV;
      ST_BT:       cmd = stat.pos_low ? CMD_EXHAUST : CMD_BT_DEC;
      ST_BT_RD:    cmd = stat.v_zero ? CMD_NONE : CMD_BT_LOWER;
      ST_MOD: begin
        if (stat.mod_reached) begin
          cmd = stat.mod_hit ? CMD_FOUND : CMD_SET_BT;
        end else begin
          cmd = CMD_MOD_STEP;
        end
      end
      ST_EMIT_LD:  cmd = CMD_LOAD_OUT;
      ST_EMIT_SHOW: begin
        out_valid = 1'b1;
        if (out_ready && !stat.last_shown) begin
          cmd = CMD_OUT_NEXT;
        end
      end
      default:     cmd = CMD_NONE;
    endcase
  end

endmodule

/* hw/rtl/fsne_dp.sv */
// Search datapath: config registers, digit store, position/period/sum state,
// bound multiplier, period divisibility accumulator and output register.
// Depends on fsne_pkg and fsne_ram.
module fsne_dp #(
  parameter int MAX_LEN    = fsne_pkg::MAX_LEN_DEF,
  parameter int ELEM_WIDTH = fsne_pkg::ELEM_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fsne_pkg::cmd_t               cmd,
  input  fsne_pkg::cfg_wr_t            cfg_wr,
  output fsne_pkg::dp_stat_t           stat,
  output logic [ELEM_WIDTH-1:0]        out_value,
  output logic [fsne_pkg::INDEX_W-1:0] out_index,
  output logic                         out_last,
  output logic                         out_done
);
  import fsne_pkg::*;

  localparam int DEPTH  = MAX_LEN + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W  = $clog2(MAX_LEN + 2);
  localparam int EW     = ELEM_WIDTH;
  localparam int TW     = (EW > SUM_CFG_W) ? EW : SUM_CFG_W;
  localparam int LW     = (POS_W > LEN_CFG_W) ? POS_W : LEN_CFG_W;
  localparam int MW     = EW + POS_W;
  localparam int EMAX   = (2 ** EW) - 2;
  localparam int RST_M  = (RST_LEN > MAX_LEN) ? MAX_LEN : RST_LEN;
  localparam int RST_D  = (RST_DEPTH > RST_M) ? RST_M : RST_DEPTH;
  localparam int RST_T  = (RST_SUM > EMAX) ? EMAX : RST_SUM;

  // config registers
  logic [LEN_CFG_W-1:0]   cfg_len_r, cfg_len_nxt;
  logic [SUM_CFG_W-1:0]   cfg_sum_r, cfg_sum_nxt;
  logic [DEPTH_CFG_W-1:0] cfg_depth_r, cfg_depth_nxt;

  // latched search parameters and search state
  logic [POS_W-1:0] m_r, m_nxt, depth_r, depth_nxt;
  logic [EW-1:0]    tot_r, tot_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt, period_r, period_nxt;
  logic [EW-1:0]    rs_r, rs_nxt, d1_r, d1_nxt;
  stage_t           stage_r, stage_nxt;
  logic             exh_r, exh_nxt;
  logic             valid_r [DEPTH];
  logic             valid_nxt [DEPTH];

  // payload registers
  logic [POS_W:0]     acc_r, acc_nxt;
  logic [POS_W-1:0]   idx_r, idx_nxt;
  logic [ADDR_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic [EW-1:0]      out_value_r, out_value_nxt;
  logic [INDEX_W-1:0] out_index_r, out_index_nxt;
  logic               out_last_r, out_last_nxt, out_done_r, out_done_nxt;

  // store port
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0]     ram_wdata, ram_q;

  fsne_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // clamped config for restart
  logic [LW-1:0]    len_ext, dep_ext, m_c, d_c;
  logic [TW-1:0]    sum_ext, t_c;
  logic [POS_W-1:0] m_init, d_init;
  logic [EW-1:0]    tot_init;

  always_comb begin
    len_ext = LW'(cfg_len_r);
    dep_ext = LW'(cfg_depth_r);
    sum_ext = TW'(cfg_sum_r);
    if (len_ext == '0) begin
      m_c = LW'(1);
    end else if (len_ext > LW'(MAX_LEN)) begin
      m_c = LW'(MAX_LEN);
    end else begin
      m_c = len_ext;
    end
    if (dep_ext == '0) begin
      d_c = LW'(1);
    end else if (dep_ext > m_c) begin
      d_c = m_c;
    end else begin
      d_c = dep_ext;
    end
    t_c      = (sum_ext > TW'(EMAX)) ? TW'(EMAX) : sum_ext;
    m_init   = POS_W'(m_c);
    d_init   = POS_W'(d_c);
    tot_init = EW'(t_c);
  end

  // search arithmetic
  logic [EW-1:0]     rem, rd_v;
  logic [POS_W-1:0]  depth_p1, left, mul_b, src, pos_m1, idx_p1, idx_p2;
  logic [MW-1:0]     prod;
  logic [EW:0]       sum_try;
  logic [ADDR_W-1:0] pos_a, pos_m1_a, src_a, idx_p2_a;

  always_comb begin
    rem      = (rs_r <= tot_r) ? tot_r - rs_r : '0;
    if (rd_addr_r == '0) begin
      rd_v = tot_r;                      // entry zero always reads as the sum
    end else begin
      rd_v = valid_r[rd_addr_r] ? ram_q : '0;
    end
    depth_p1 = depth_r + POS_W'(1);
    left     = m_r + POS_W'(1) - pos_r;
    mul_b    = (pos_r >= depth_p1) ? (m_r - depth_r) : left;
    prod     = MW'(d1_r) * MW'(mul_b);
    sum_try  = {1'b0, rs_r} + {1'b0, rd_v};
    src      = (period_r <= pos_r) ? pos_r - period_r : '0;
    pos_m1   = pos_r - POS_W'(1);
    idx_p1   = idx_r + POS_W'(1);
    idx_p2   = idx_r + POS_W'(2);
    pos_a    = pos_r[ADDR_W-1:0];
    pos_m1_a = pos_m1[ADDR_W-1:0];
    src_a    = src[ADDR_W-1:0];
    idx_p2_a = idx_p2[ADDR_W-1:0];
  end

  always_comb begin
    stat.past_depth  = (pos_r >= depth_p1);
    stat.full_len    = (depth_r == m_r);
    stat.sum_ok      = (rs_r == tot_r) && (period_r != '0);
    stat.tail_ok     = (prod >= MW'(rem));
    stat.t_ge2       = (pos_r >= POS_W'(2));
    stat.bound_fail  = (prod < MW'(rem));
    stat.fit         = (sum_try <= {1'b0, tot_r});
    stat.v_gt_rem    = (rd_v > rem);
    stat.v_zero      = (rd_v == '0);
    stat.pos_low     = (pos_r <= POS_W'(1));
    stat.mod_reached = (acc_r >= {1'b0, m_r});
    stat.mod_hit     = (acc_r == {1'b0, m_r});
    stat.last_shown  = out_last_r;
    stat.exhausted   = exh_r;
    stat.stage       = stage_r;
  end

  // command decode
  always_comb begin
    cfg_len_nxt   = cfg_len_r;
    cfg_sum_nxt   = cfg_sum_r;
    cfg_depth_nxt = cfg_depth_r;
    m_nxt         = m_r;
    depth_nxt     = depth_r;
    tot_nxt       = tot_r;
    pos_nxt       = pos_r;
    period_nxt    = period_r;
    rs_nxt        = rs_r;
    d1_nxt        = d1_r;
    stage_nxt     = stage_r;
    exh_nxt       = exh_r;
    valid_nxt     = valid_r;
    acc_nxt       = acc_r;
    idx_nxt       = idx_r;
    rd_addr_nxt   = rd_addr_r;
    out_value_nxt = out_value_r;
    out_index_nxt = out_index_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_a;
    ram_wdata     = rd_v;
    ram_re        = 1'b0;
    ram_raddr     = src_a;

    if (cfg_wr.we) begin
      unique case (cfg_wr.idx)
        REG_SEQ_LENGTH: cfg_len_nxt   = cfg_wr.data[LEN_CFG_W-1:0];
        REG_TARGET_SUM: cfg_sum_nxt   = cfg_wr.data[SUM_CFG_W-1:0];
        REG_EMIT_DEPTH: cfg_depth_nxt = cfg_wr.data[DEPTH_CFG_W-1:0];
        default: ;
      endcase
    end

    unique case (cmd)
      CMD_INIT: begin
        m_nxt      = m_init;
        depth_nxt  = d_init;
        tot_nxt    = tot_init;
        pos_nxt    = POS_W'(1);
        period_nxt = POS_W'(1);
        rs_nxt     = '0;
        d1_nxt     = '0;
        stage_nxt  = STG_DESCEND;
        exh_nxt    = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
          valid_nxt[i] = 1'b0;
        end
      end
      CMD_SET_BT: stage_nxt = STG_BACKTRACK;
      CMD_RD_SRC: begin
        ram_re    = 1'b1;
        ram_raddr = src_a;
      end
      CMD_DESC_ADV: begin
        ram_we    = 1'b1;
        ram_wdata = rd_v;
        rs_nxt    = sum_try[EW-1:0];
        pos_nxt   = pos_r + POS_W'(1);
      end
      CMD_DESC_LOOP: begin
        ram_we    = 1'b1;
        ram_wdata = rem;
        stage_nxt = STG_LOOP;
      end
      CMD_RD_T: begin
        ram_re    = 1'b1;
        ram_raddr = pos_a;
      end
      CMD_LOOP_ADV: begin
        rs_nxt     = sum_try[EW-1:0];
        pos_nxt    = pos_r + POS_W'(1);
        period_nxt = pos_r;
        stage_nxt  = STG_DESCEND;
      end
      CMD_BT_DEC: begin
        pos_nxt   = pos_m1;
        ram_re    = 1'b1;
        ram_raddr = pos_m1_a;
      end
      CMD_BT_LOWER: begin
        rs_nxt    = rs_r - rd_v;             // wraps like the element width
        ram_we    = 1'b1;
        ram_wdata = rd_v - EW'(1);
        stage_nxt = STG_LOOP;
      end
      CMD_EXHAUST: begin
        exh_nxt       = 1'b1;
        out_value_nxt = '0;
        out_index_nxt = '0;
        out_last_nxt  = 1'b1;
        out_done_nxt  = 1'b1;
      end
      CMD_MOD_START: acc_nxt = {1'b0, period_r};
      CMD_MOD_STEP:  acc_nxt = acc_r + {1'b0, period_r};
      CMD_FOUND: begin
        stage_nxt = STG_BACKTRACK;
        idx_nxt   = '0;
        ram_re    = 1'b1;
        ram_raddr = ADDR_W'(1);
      end
      CMD_LOAD_OUT: begin
        out_value_nxt = rd_v;
        out_index_nxt = INDEX_W'(idx_r);
        out_last_nxt  = (idx_p1 == depth_r);
        out_done_nxt  = 1'b0;
      end
      CMD_OUT_NEXT: begin
        idx_nxt   = idx_p1;
        ram_re    = 1'b1;
        ram_raddr = idx_p2_a;
      end
      default: ;
    endcase

    if (ram_we) begin
      valid_nxt[ram_waddr] = 1'b1;
      if (ram_waddr == ADDR_W'(1)) begin
        d1_nxt = ram_wdata;
      end
    end
    if (ram_re) begin
      rd_addr_nxt = ram_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r   <= LEN_CFG_W'(RST_LEN);
      cfg_sum_r   <= SUM_CFG_W'(RST_SUM);
      cfg_depth_r <= DEPTH_CFG_W'(RST_DEPTH);
      m_r         <= POS_W'(RST_M);
      depth_r     <= POS_W'(RST_D);
      tot_r       <= EW'(RST_T);
      pos_r       <= POS_W'(1);
      period_r    <= POS_W'(1);
      rs_r        <= '0;
      d1_r        <= '0;
      stage_r     <= STG_DESCEND;
      exh_r       <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      cfg_len_r   <= cfg_len_nxt;
      cfg_sum_r   <= cfg_sum_nxt;
      cfg_depth_r <= cfg_depth_nxt;
      m_r         <= m_nxt;
      depth_r     <= depth_nxt;
      tot_r       <= tot_nxt;
      pos_r       <= pos_nxt;
      period_r    <= period_nxt;
      rs_r        <= rs_nxt;
      d1_r        <= d1_nxt;
      stage_r     <= stage_nxt;
      exh_r       <= exh_nxt;
      valid_r     <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    idx_r       <= idx_nxt;
    rd_addr_r   <= rd_addr_nxt;
    out_value_r <= out_value_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign out_value = out_value_r;
  assign out_index = out_index_r;
  assign out_last  = out_last_r;
  assign out_done  = out_done_r;

endmodule

/* hw/rtl/fixed_sum_necklace_enumerator_core.sv */
// Top level of the fixed-sum necklace enumerator: sequencer plus datapath.
// Depends on fsne_pkg, fsne_if, fsne_ctrl, fsne_dp (and fsne_ram below it).
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   restart
//  out_ch   out  valid/ready   element_value, element_index, last_element, done_res
//  cfg_ch   in   valid/ready   index (0 length, 1 sum, 2 depth), data
//
// Search: a restart item yields no result. A next-item request runs the search
// as descend, loop and backtrack steps that read the digit store and then use
// the data, all bound by its single read port; a full-length candidate adds a
// period check that steps the accumulator by the period up to m.
// Each result element then passes through a store read and the output register.
// Reset: the store's entries are qualified by flip-flop valid bits, so neither
// reset nor restart needs a clearing pass.
// Stalls: requests are taken only while idle; out_ready low holds the current
// element in the output register. cfg_ready is always high.
module fixed_sum_necklace_enumerator_core #(
  parameter int MAX_LEN    = fsne_pkg::MAX_LEN_DEF,
  parameter int ELEM_WIDTH = fsne_pkg::ELEM_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  fsne_in_if.sink    in_ch,
  fsne_out_if.source out_ch,
  fsne_cfg_if.sink   cfg_ch
);
  import fsne_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;
  cfg_wr_t  cfg_wr;

  logic [ELEM_WIDTH-1:0] out_value;
  logic [INDEX_W-1:0]    out_index;
  logic                  out_last;
  logic                  out_done;

  // config port never stalls; writes land straight in the datapath registers
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr.we    = cfg_ch.valid;
  assign cfg_wr.idx   = cfg_ch.index;
  assign cfg_wr.data  = cfg_ch.data;

  fsne_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_restart (in_ch.restart),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  fsne_dp #(
    .MAX_LEN    (MAX_LEN),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_wr    (cfg_wr),
    .stat      (stat),
    .out_value (out_value),
    .out_index (out_index),
    .out_last  (out_last),
    .out_done  (out_done)
  );

  // result payload comes straight from the datapath output register
  assign out_ch.element_value = out_value;
  assign out_ch.element_index = out_index;
  assign out_ch.last_element  = out_last;
  assign out_ch.done_res      = out_done;

endmodule

/* hw/rtl/fsne_checker.sv */
// Port-level assertions for the necklace enumerator, bound to the top level.
// Depends on fsne_pkg and fixed_sum_necklace_enumerator_core.
module fsne_checker #(
  parameter int ELEM_W = fsne_pkg::ELEM_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_restart,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ELEM_W-1:0]            out_value,
  input logic [fsne_pkg::INDEX_W-1:0] out_index,
  input logic                         out_last,
  input logic                         out_done
);

  // a stalled element holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) &&
    $stable(out_index) && $stable(out_last) && $stable(out_done))
    else $error("stalled result changed");

  // requests and results never overlap
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while a result is pending");

  // done result carries zeros and closes the vector
  a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done |-> out_last && out_value == '0 && out_index == '0)
    else $error("malformed done result");

  // mid-vector the block stays busy
  a_vector_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !in_ready)
    else $error("request window opened inside a vector");

  // restart produces nothing and leaves the block idle
  a_restart_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_restart |=> in_ready && !out_valid)
    else $error("restart produced a result");

endmodule

bind fixed_sum_necklace_enumerator_core fsne_checker #(
  .ELEM_W (ELEM_WIDTH)
) u_fsne_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_restart (in_ch.restart),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_value  (out_ch.element_value),
  .out_index  (out_ch.element_index),
  .out_last   (out_ch.last_element),
  .out_done   (out_ch.done_res)
);
